/* sv/page_bitmap_allocator_assert.svh */
// ----------------------------------------------------------------------------
// Page bitmap allocator assertion macros
// Concurrent check wrappers; they compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PAGE_BITMAP_ALLOCATOR_ASSERT_SVH
`define PAGE_BITMAP_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define PBA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PBA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define PBA_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define PBA_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

/* sv/pba_pkg.sv */
// ----------------------------------------------------------------------------
// Page bitmap allocator package
// Sizes, codes and the types shared by the allocator's modules.
// ----------------------------------------------------------------------------
package pba_pkg;

   localparam int MAX_PAGES   = 4096;
   localparam int WORD_BITS   = 32;
   localparam int PAGE_SHIFT  = 12;
   localparam int ADDR_W      = 32;

   localparam int MAP_WORDS   = MAX_PAGES / WORD_BITS;
   localparam int PAGE_W      = $clog2(MAX_PAGES);
   localparam int COUNT_W     = PAGE_W + 1;
   localparam int WORD_IDX_W  = $clog2(MAP_WORDS);
   localparam int BIT_IDX_W   = $clog2(WORD_BITS);
   localparam int PFN_W       = ADDR_W - PAGE_SHIFT;

   // two-level search over the word summary
   localparam int GROUPS      = 8;
   localparam int GROUP_SIZE  = MAP_WORDS / GROUPS;
   localparam int GROUP_W     = $clog2(GROUPS);
   localparam int GIDX_W      = $clog2(GROUP_SIZE);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 1;

   typedef enum logic {
      KIND_ALLOC = 1'b0,
      KIND_FREE  = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK            = 2'd0,
      STATUS_NO_PAGE       = 2'd1,
      STATUS_OUT_OF_REGION = 2'd2
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_REGION_BASE = 1'b0,
      CSR_PAGE_COUNT  = 1'b1
   } csr_index_type;

   // classified request as it sits in the queue
   typedef struct packed {
      kind_type              kind;
      logic                  bad;
      logic [PAGE_W-1:0]     page;
   } req_entry_type;

   typedef struct packed {
      logic                  valid;
      req_entry_type         entry;
   } queue_head_type;

   typedef struct packed {
      logic                  reinit;
      logic [COUNT_W-1:0]    total;
   } reinit_type;

endpackage

/* sv/pba_req_if.sv */
// ----------------------------------------------------------------------------
// Page bitmap allocator request channel
// Valid/ready channel carrying one allocate or free request per word.
// ----------------------------------------------------------------------------
interface pba_req_if import pba_pkg::*; ();

   logic                valid;
   logic                ready;
   logic                kind;
   logic [ADDR_W-1:0]   page_address;

   modport source (output valid, output kind, output page_address, input ready);
   modport sink   (input valid, input kind, input page_address, output ready);

endinterface

/* sv/pba_rsp_if.sv */
// ----------------------------------------------------------------------------
// Page bitmap allocator response channel
// Valid/ready channel carrying one result word per request.
// ----------------------------------------------------------------------------
interface pba_rsp_if import pba_pkg::*; ();

   logic                valid;
   logic                ready;
   logic [ADDR_W-1:0]   granted_address;
   logic [1:0]          status;
   logic [COUNT_W-1:0]  free_pages;

   modport source (output valid, output granted_address, output status,
                   output free_pages, input ready);
   modport sink   (input valid, input granted_address, input status,
                   input free_pages, output ready);

endinterface

/* sv/pba_front.sv */
// ----------------------------------------------------------------------------
// Page bitmap allocator front end
// Accepts requests, range-checks free addresses and queues them for the back.
// ----------------------------------------------------------------------------
module pba_front import pba_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   pba_req_if.sink               req,
   input  logic [ADDR_W-1:0]     region_base,
   input  logic [COUNT_W-1:0]    page_count,
   input  logic                  pop,
   output queue_head_type        head
);

   logic [ADDR_W-1:0]   offset;
   logic [PFN_W-1:0]    pfn;
   logic                below;
   logic                beyond;
   logic                push;
   req_entry_type       entry;

   req_entry_type       q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;

   always_comb begin
      offset       = req.page_address - region_base;
      pfn          = offset[ADDR_W-1:PAGE_SHIFT];
      below        = req.page_address < region_base;
      beyond       = pfn >= PFN_W'(page_count);
      entry.kind   = kind_type'(req.kind);
      entry.bad    = (req.kind == KIND_FREE) && (below || beyond);
      entry.page   = pfn[PAGE_W-1:0];
   end

   assign req.ready  = cnt_ff != QCNT_W'(QUEUE_DEPTH);
   assign push       = req.valid && req.ready;
   assign head.valid = cnt_ff != '0;
   assign head.entry = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

/* sv/pba_back.sv */
// ----------------------------------------------------------------------------
// Page bitmap allocator back end
// Free-map RAM, word summary search, free count and the response register.
// ----------------------------------------------------------------------------
module pba_back import pba_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  queue_head_type        head,
   output logic                  pop,
   input  reinit_type            reinit,
   input  logic [ADDR_W-1:0]     region_base,
   input  logic [COUNT_W-1:0]    page_count,
   pba_rsp_if.source             rsp
);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_PICK   = 4'b0010,
      S_READ   = 4'b0100,
      S_UPDATE = 4'b1000
   } state_type;

   // pages below total in word w
   function automatic logic [WORD_BITS-1:0] init_word(input logic [WORD_IDX_W-1:0] w,
                                                      input logic [COUNT_W-1:0] total);
      logic [COUNT_W-1:0]   lo;
      logic [WORD_BITS-1:0] ones;
      logic [WORD_BITS-1:0] m;
      lo   = COUNT_W'({w, {BIT_IDX_W{1'b0}}});
      ones = '1;
      if (total <= lo) begin
         m = '0;
      end else if (total - lo >= COUNT_W'(WORD_BITS)) begin
         m = ones;
      end else begin
         m = ~(ones << total[BIT_IDX_W-1:0]);
      end
      return m;
   endfunction

   function automatic logic [MAP_WORDS-1:0] summ_init(input logic [COUNT_W-1:0] total);
      logic [MAP_WORDS-1:0] s;
      for (int w = 0; w < MAP_WORDS; w++) begin
         s[w] = COUNT_W'(w * WORD_BITS) < total;
      end
      return s;
   endfunction

   function automatic logic [BIT_IDX_W-1:0] lowest_bit(input logic [WORD_BITS-1:0] v);
      logic [BIT_IDX_W-1:0] idx;
      idx = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (v[i]) idx = BIT_IDX_W'(i);
      end
      return idx;
   endfunction

   function automatic logic [GIDX_W-1:0] lowest_word(input logic [GROUP_SIZE-1:0] v);
      logic [GIDX_W-1:0] idx;
      idx = '0;
      for (int i = GROUP_SIZE - 1; i >= 0; i--) begin
         if (v[i]) idx = GIDX_W'(i);
      end
      return idx;
   endfunction

   state_type              state_ff, state_in;
   kind_type               cur_kind_ff, cur_kind_in;
   status_type             cur_status_ff, cur_status_in;
   logic [WORD_IDX_W-1:0]  cur_word_ff, cur_word_in;
   logic [BIT_IDX_W-1:0]   cur_bit_ff, cur_bit_in;

   logic [GROUPS-1:0]      grp_any_ff, grp_any_in;
   logic [GIDX_W-1:0]      grp_idx_ff [GROUPS];
   logic [GIDX_W-1:0]      grp_idx_in [GROUPS];
   logic                   pick_any;
   logic [GROUP_W-1:0]     pick_grp;

   logic [MAP_WORDS-1:0]   summ_ff, summ_in;
   logic [MAP_WORDS-1:0]   row_valid_ff, row_valid_in;
   logic [WORD_BITS-1:0]   map_mem [MAP_WORDS];
   logic [WORD_BITS-1:0]   rd_data_ff;
   logic                   rd_valid_ff;
   logic                   mem_we;

   logic [COUNT_W-1:0]     free_total_ff, free_total_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]      rsp_addr_ff, rsp_addr_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]     rsp_free_ff, rsp_free_in;

   logic [WORD_BITS-1:0]   word_cur;
   logic [WORD_BITS-1:0]   bit_mask;
   logic [WORD_BITS-1:0]   new_word;
   logic [BIT_IDX_W-1:0]   bit_sel;
   logic [PAGE_W-1:0]      page_sel;
   logic [ADDR_W-1:0]      granted;
   logic                   out_free;

   // first stage of the search: per-group any and lowest word
   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         grp_any_in[g] = |summ_ff[g*GROUP_SIZE +: GROUP_SIZE];
         grp_idx_in[g] = lowest_word(summ_ff[g*GROUP_SIZE +: GROUP_SIZE]);
      end
   end

   // second stage: lowest nonempty group
   always_comb begin
      pick_any = |grp_any_ff;
      pick_grp = '0;
      for (int g = GROUPS - 1; g >= 0; g--) begin
         if (grp_any_ff[g]) pick_grp = GROUP_W'(g);
      end
   end

   always_comb begin
      word_cur = rd_valid_ff ? rd_data_ff : init_word(cur_word_ff, page_count);
      bit_sel  = (cur_kind_ff == KIND_ALLOC) ? lowest_bit(word_cur) : cur_bit_ff;
      bit_mask = WORD_BITS'(1) << bit_sel;
      new_word = (cur_kind_ff == KIND_ALLOC) ? (word_cur & ~bit_mask) : (word_cur | bit_mask);
      page_sel = {cur_word_ff, bit_sel};
      granted  = region_base + (ADDR_W'(page_sel) << PAGE_SHIFT);
      out_free = !rsp_valid_ff || rsp.ready;
   end

   always_comb begin
      state_in      = state_ff;
      cur_kind_in   = cur_kind_ff;
      cur_status_in = cur_status_ff;
      cur_word_in   = cur_word_ff;
      cur_bit_in    = cur_bit_ff;
      summ_in       = summ_ff;
      row_valid_in  = row_valid_ff;
      free_total_in = free_total_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      rsp_free_in   = rsp_free_ff;
      pop           = 1'b0;
      mem_we        = 1'b0;

      if (rsp_valid_ff && rsp.ready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (head.valid) begin
               pop           = 1'b1;
               cur_kind_in   = head.entry.kind;
               cur_word_in   = head.entry.page[PAGE_W-1:BIT_IDX_W];
               cur_bit_in    = head.entry.page[BIT_IDX_W-1:0];
               cur_status_in = STATUS_OK;
               if (head.entry.kind == KIND_ALLOC) begin
                  state_in = S_PICK;
               end else if (head.entry.bad) begin
                  cur_status_in = STATUS_OUT_OF_REGION;
                  state_in      = S_UPDATE;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_PICK: begin
            if (pick_any) begin
               cur_word_in = {pick_grp, grp_idx_ff[pick_grp]};
               state_in    = S_READ;
            end else begin
               cur_status_in = STATUS_NO_PAGE;
               state_in      = S_UPDATE;
            end
         end
         S_READ: begin
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            if (out_free) begin
               state_in      = S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = cur_status_ff;
               rsp_addr_in   = '0;
               if (cur_status_ff == STATUS_OK) begin
                  mem_we                    = 1'b1;
                  row_valid_in[cur_word_ff] = 1'b1;
                  summ_in[cur_word_ff]      = |new_word;
                  if (cur_kind_ff == KIND_ALLOC) begin
                     rsp_addr_in = granted;
                     if (free_total_ff != '0) free_total_in = free_total_ff - COUNT_W'(1);
                  end else if (free_total_ff < page_count) begin
                     free_total_in = free_total_ff + COUNT_W'(1);
                  end
               end
               rsp_free_in = free_total_in;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // page_count write: rows read back as their initial pattern until touched
      if (reinit.reinit) begin
         row_valid_in  = '0;
         summ_in       = summ_init(reinit.total);
         free_total_in = reinit.total;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cur_status_ff <= STATUS_OK;
         grp_any_ff    <= '0;
         summ_ff       <= summ_init(COUNT_W'(MAX_PAGES));
         row_valid_ff  <= '0;
         free_total_ff <= COUNT_W'(MAX_PAGES);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cur_status_ff <= cur_status_in;
         grp_any_ff    <= grp_any_in;
         summ_ff       <= summ_in;
         row_valid_ff  <= row_valid_in;
         free_total_ff <= free_total_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_kind_ff   <= cur_kind_in;
      cur_word_ff   <= cur_word_in;
      cur_bit_ff    <= cur_bit_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_free_ff   <= rsp_free_in;
      for (int g = 0; g < GROUPS; g++) begin
         grp_idx_ff[g] <= grp_idx_in[g];
      end
   end

   // free-map RAM, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[cur_word_ff] <= new_word;
      end
      if (state_ff == S_READ) begin
         rd_data_ff  <= map_mem[cur_word_ff];
         rd_valid_ff <= row_valid_ff[cur_word_ff];
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.granted_address = rsp_addr_ff;
   assign rsp.status          = rsp_status_ff;
   assign rsp.free_pages      = rsp_free_ff;

endmodule

/* sv/page_bitmap_allocator.sv */
// ----------------------------------------------------------------------------
// Page bitmap allocator
// First-fit page frame allocator over a one-bit-per-page free map.
// ----------------------------------------------------------------------------
//  Channel  Port    Direction  Word
//  request  req     in         kind, page_address
//  result   rsp     out        granted_address, status, free_pages
//  config   csr_*   in         csr_index, csr_wdata (no read-back)
//
//  The back end handles one request at a time, paced by the two-stage
//  summary search and the map RAM's registered read; out-of-region frees
//  skip the read, and allocates skip it when no page is free.
//  Synchronous reset; the map needs no clearing pass (per-row valid bits).
//  A two-entry queue and the result register let either side stall alone.
// ----------------------------------------------------------------------------
`include "page_bitmap_allocator_assert.svh"

module page_bitmap_allocator import pba_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   pba_req_if.sink                  req,
   pba_rsp_if.source                rsp,
   input  logic                     csr_wr_en,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_wdata
);

   logic [ADDR_W-1:0]   region_base_ff, region_base_in;
   logic [COUNT_W-1:0]  page_count_ff, page_count_in;
   logic [COUNT_W-1:0]  count_raw;
   logic [COUNT_W-1:0]  count_sat;
   reinit_type          reinit;
   queue_head_type      head;
   logic                pop;

   always_comb begin
      count_raw      = csr_wdata[COUNT_W-1:0];
      count_sat      = (count_raw > COUNT_W'(MAX_PAGES)) ? COUNT_W'(MAX_PAGES) : count_raw;
      region_base_in = region_base_ff;
      page_count_in  = page_count_ff;
      reinit.reinit  = 1'b0;
      reinit.total   = count_sat;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_REGION_BASE: region_base_in = csr_wdata[ADDR_W-1:0];
            CSR_PAGE_COUNT: begin
               page_count_in = count_sat;
               reinit.reinit = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         region_base_ff <= '0;
         page_count_ff  <= COUNT_W'(MAX_PAGES);
      end else begin
         region_base_ff <= region_base_in;
         page_count_ff  <= page_count_in;
      end
   end

   pba_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .region_base (region_base_ff),
      .page_count  (page_count_ff),
      .pop         (pop),
      .head        (head)
   );

   pba_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .pop         (pop),
      .reinit      (reinit),
      .region_base (region_base_ff),
      .page_count  (page_count_ff),
      .rsp         (rsp)
   );

   `PBA_ASSERT_NOW(a_pop_needs_head, clock, reset, pop, head.valid, "pop from empty queue")
   `PBA_ASSERT_NEXT(a_pop_spaced, clock, reset, pop, !pop, "back end popped twice in a row")
   `PBA_ASSERT_NOW(a_fail_no_addr, clock, reset, rsp.valid && (rsp.status != STATUS_OK), rsp.granted_address == '0, "failed request returned an address")
   `PBA_ASSERT_NOW(a_count_bound, clock, reset, rsp.valid, rsp.free_pages <= page_count_ff, "free count above page total")

endmodule

/* dv/pba_grant_checker.sv */
// ----------------------------------------------------------------------------
// Page bitmap allocator result checker
// Watches the request, result and register ports, keeps its own free map and
// count, and compares every result word with the oldest predicted one.
// ----------------------------------------------------------------------------
module pba_grant_checker import pba_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   pba_req_if                       req,
   pba_rsp_if                       rsp,
   input  logic                     csr_wr_en,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_wdata,
   output int                       mismatch_count,
   output int                       pending_words
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [ADDR_W-1:0]   granted_address;
      status_type          status;
      logic [COUNT_W-1:0]  free_pages;
   } outcome_type;

   logic [MAX_PAGES-1:0]   free_map;
   logic [COUNT_W-1:0]     page_total;
   logic [COUNT_W-1:0]     free_total;
   logic [ADDR_W-1:0]      region_base;
   outcome_type            awaited_outcomes[$];

   // every page below the total free, count back at the total
   function automatic void refill_map();
      free_map = '0;
      for (int p = 0; p < int'(page_total); p++)
         free_map[p] = 1'b1;
      free_total = page_total;
   endfunction

   function automatic outcome_type serve_request(input logic kind,
                                                 input logic [ADDR_W-1:0] address);
      outcome_type        o;
      logic [ADDR_W-1:0]  page_no;
      bit                 found;
      o.granted_address = '0;
      o.status = STATUS_OK;
      found = 1'b0;
      if (kind == KIND_ALLOC) begin
         // first fit: lowest free page below the total
         for (int p = 0; p < int'(page_total) && !found; p++) begin
            if (free_map[p]) begin
               free_map[p] = 1'b0;
               if (free_total > 0)
                  free_total = free_total - 1'b1;
               page_no = p;
               o.granted_address = region_base + (page_no << PAGE_SHIFT);
               found = 1'b1;
            end
         end
         if (!found)
            o.status = STATUS_NO_PAGE;
      end else if (address < region_base) begin
         o.status = STATUS_OUT_OF_REGION;
      end else begin
         page_no = (address - region_base) >> PAGE_SHIFT;
         if (page_no >= page_total) begin
            o.status = STATUS_OUT_OF_REGION;
         end else begin
            // double free keeps the bit, count still moves but saturates
            free_map[page_no[PAGE_W-1:0]] = 1'b1;
            if (free_total < page_total)
               free_total = free_total + 1'b1;
         end
      end
      o.free_pages = free_total;
      return o;
   endfunction

   always @(posedge clock) begin : watch
      outcome_type         want;
      outcome_type         got;
      logic [COUNT_W-1:0]  written;
      if (reset) begin
         region_base = '0;
         page_total = COUNT_W'(MAX_PAGES);
         refill_map();
         awaited_outcomes.delete();
         mismatch_count = 0;
         pending_words = 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            got.granted_address = rsp.granted_address;
            got.status = status_type'(rsp.status);
            got.free_pages = rsp.free_pages;
            if (awaited_outcomes.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected result word: grant %h status %0d free %0d",
                           $realtime, got.granted_address, got.status, got.free_pages);
            end else begin
               want = awaited_outcomes.pop_front();
               if (got.granted_address !== want.granted_address ||
                   got.status !== want.status ||
                   got.free_pages !== want.free_pages) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%0t: result mismatch: expected grant %h status %0d free %0d, %s",
                              $realtime, want.granted_address, want.status,
                              want.free_pages,
                              $sformatf("got grant %h status %0d free %0d",
                                        got.granted_address, got.status,
                                        got.free_pages));
               end
            end
         end
         if (req.valid && req.ready)
            awaited_outcomes.push_back(serve_request(req.kind, req.page_address));
         if (csr_wr_en) begin
            case (csr_index)
               CSR_REGION_BASE: begin
                  region_base = csr_wdata[ADDR_W-1:0];
               end
               CSR_PAGE_COUNT: begin
                  written = csr_wdata[COUNT_W-1:0];
                  if (written > MAX_PAGES)
                     written = COUNT_W'(MAX_PAGES);
                  page_total = written;
                  refill_map();
               end
               default: begin
               end
            endcase
         end
         pending_words = awaited_outcomes.size();
      end
   end

endmodule

/* dv/page_bitmap_allocator_tb.sv */
// ----------------------------------------------------------------------------
// Page bitmap allocator testbench
// Directed allocate/free words over boundary settings, then random phases
// with fresh region settings, random gaps on both channels and full drains.
// ----------------------------------------------------------------------------
module page_bitmap_allocator_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pba_pkg::*;

   localparam int RANDOM_WORDS = 1300;

   logic                     clock;
   logic                     reset;
   logic                     csr_wr_en;
   logic [CSR_INDEX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]    csr_wdata;
   int                       mismatch_count;
   int                       pending_words;
   bit                       idle_on;
   logic [ADDR_W-1:0]        cur_base;
   int                       cur_total;

   pba_req_if req_if();
   pba_rsp_if rsp_if();

   page_bitmap_allocator uut (
      .clock      (clock),
      .reset      (reset),
      .req        (req_if),
      .rsp        (rsp_if),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   pba_grant_checker grant_check (
      .clock          (clock),
      .reset          (reset),
      .req            (req_if),
      .rsp            (rsp_if),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_words  (pending_words)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // mostly short stalls, now and then a long one
   function automatic int gap_len();
      if ($urandom_range(0, 99) < 85)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // result side: ready drops in random runs while idling is on
   initial begin : result_sink
      int stall;
      stall = 0;
      rsp_if.ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         if (stall == 0 && idle_on && $urandom_range(0, 99) < 30)
            stall = gap_len();
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            stall--;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_word(input kind_type kind, input logic [ADDR_W-1:0] address);
      int gap;
      gap = (idle_on && $urandom_range(0, 99) < 40) ? gap_len() : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.kind <= kind;
      req_if.page_address <= address;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
   endtask

   // hold off until every word sent has its result back
   task automatic drain();
      req_if.valid <= 1'b0;
      do @(negedge clock); while (pending_words != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_config(input bit set_base, input logic [ADDR_W-1:0] base,
                               input bit set_count, input logic [CSR_DATA_W-1:0] count_word);
      if (set_base) begin
         csr_wr_en <= 1'b1;
         csr_index <= CSR_REGION_BASE;
         csr_wdata <= base;
         cur_base = base;
         @(negedge clock);
      end
      if (set_count) begin
         csr_wr_en <= 1'b1;
         csr_index <= CSR_PAGE_COUNT;
         csr_wdata <= count_word;
         cur_total = count_word[COUNT_W-1:0];
         if (cur_total > MAX_PAGES)
            cur_total = MAX_PAGES;
         @(negedge clock);
      end
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic send_random(input int alloc_pct);
      logic [ADDR_W-1:0]  address;
      logic [ADDR_W-1:0]  page_no;
      logic [ADDR_W-1:0]  offset;
      int                 pick;
      offset = ($urandom_range(0, 1) == 0) ? '0 : $urandom_range(0, 4095);
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < alloc_pct) begin
         send_word(KIND_ALLOC, $urandom());
      end else begin
         if (pick < 70 && cur_total > 0) begin
            page_no = $urandom_range(0, cur_total - 1);
            address = cur_base + (page_no << PAGE_SHIFT) + offset;
         end else if (pick < 85 && cur_base != 0) begin
            address = $urandom_range(0, cur_base - 1);
         end else if (pick < 92) begin
            page_no = cur_total + $urandom_range(0, 3);
            address = cur_base + (page_no << PAGE_SHIFT) + offset;
         end else begin
            address = $urandom();
         end
         send_word(KIND_FREE, address);
      end
   endtask

   initial begin : stimulus
      int                     words_sent;
      int                     phase_len;
      int                     alloc_pct;
      int                     pick;
      int                     total_pick;
      logic [ADDR_W-1:0]      base_pick;
      logic [CSR_DATA_W-1:0]  count_word;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = CSR_REGION_BASE;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.kind = KIND_ALLOC;
      req_if.page_address = '0;
      idle_on = 1'b1;
      cur_base = '0;
      cur_total = MAX_PAGES;
      words_sent = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: base zero, full page total
      send_word(KIND_FREE, 32'h0000_5000);   // already free at full count
      send_word(KIND_ALLOC, 32'hFFFF_FFFF);
      send_word(KIND_ALLOC, 32'h0000_0000);
      send_word(KIND_ALLOC, 32'h1234_5678);
      send_word(KIND_FREE, 32'h0000_0FFF);   // unaligned, page zero
      send_word(KIND_FREE, 32'h0000_1000);
      send_word(KIND_FREE, 32'h0000_1000);   // double free
      send_word(KIND_FREE, 32'hFFFF_FFFF);
      send_word(KIND_FREE, 32'h0100_0000);   // first page past the total
      send_word(KIND_ALLOC, 32'h0000_0000);
      drain();

      // top of the address space: second page wraps to zero, then exhaustion
      write_config(1'b1, 32'hFFFF_F000, 1'b1, 32'd2);
      send_word(KIND_ALLOC, 32'h0000_0000);
      send_word(KIND_ALLOC, 32'h0000_0000);
      send_word(KIND_ALLOC, 32'h0000_0000);
      send_word(KIND_FREE, 32'h0000_0000);   // below base
      send_word(KIND_FREE, 32'hFFFF_F123);
      send_word(KIND_FREE, 32'hFFFF_FFFF);
      send_word(KIND_ALLOC, 32'hFFFF_FFFF);
      drain();

      // no pages at all
      write_config(1'b0, '0, 1'b1, 32'd0);
      send_word(KIND_ALLOC, 32'h0000_0000);
      send_word(KIND_FREE, 32'hFFFF_F000);
      send_word(KIND_FREE, 32'h0000_0000);
      drain();

      // oversized total saturates; upper data bits are dropped
      write_config(1'b1, 32'h0040_0000, 1'b1, 32'hFFFF_FFFF);
      send_word(KIND_FREE, 32'h003F_FFFF);
      send_word(KIND_ALLOC, 32'h0000_0000);
      send_word(KIND_FREE, 32'h013F_F000);   // last page of the region

      while (words_sent < RANDOM_WORDS) begin
         drain();
         idle_on = ($urandom_range(0, 3) != 0);
         pick = $urandom_range(0, 2);
         if (pick == 0)
            base_pick = '0;
         else if (pick == 1 && $urandom_range(0, 1) == 0)
            base_pick = 32'hFFFF_F000;
         else
            base_pick = {20'($urandom_range(0, 20'hFFFFF)), 12'h000};
         pick = $urandom_range(0, 19);
         if (pick == 0)
            total_pick = 0;
         else if (pick <= 8)
            total_pick = $urandom_range(1, 40);
         else if (pick <= 11)
            total_pick = $urandom_range(41, 300);
         else if (pick <= 13)
            total_pick = MAX_PAGES;
         else if (pick <= 15)
            total_pick = $urandom_range(MAX_PAGES + 1, 8191);
         else
            total_pick = $urandom_range(1, MAX_PAGES);
         count_word = total_pick;
         if ($urandom_range(0, 4) == 0)
            count_word = ($urandom() & 32'hFFFF_E000) | count_word;
         pick = $urandom_range(0, 9);
         write_config(pick <= 7, base_pick, pick <= 5 || pick >= 8, count_word);
         case ($urandom_range(0, 3))
            0: alloc_pct = 30;
            1: alloc_pct = 50;
            2: alloc_pct = 70;
            default: alloc_pct = 85;
         endcase
         phase_len = $urandom_range(40, 160);
         repeat (phase_len) begin
            send_random(alloc_pct);
            words_sent++;
            if ($urandom_range(0, 99) == 0)
               drain();
         end
      end

      req_if.valid <= 1'b0;
      while (pending_words != 0) @(negedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && pending_words == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
